[rtl/positional_list_engine_macros.svh]
// assertion helpers for the positional list engine
// both sample on clk and stay quiet while rst_n is low
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// property must hold at every sampled edge
`define PLE_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen
`define PLE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/ple_pkg.sv]
`default_nettype none

package ple_pkg;

    // action codes carried by an input beat
    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_SORT   = 3'd3,
        ACT_DUMP   = 3'd4
    } action_t;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_POS = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // per-cycle operation broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_INS  = 3'd1,
        CELL_DEL  = 3'd2,
        CELL_SORT = 3'd3,
        CELL_ROT  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/ple_cell.sv]
`default_nettype none

module ple_cell #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  wire                                  clk,
    input  ple_pkg::cell_cmd_t                   cmd,
    input  wire  [$clog2(CAPACITY)-1:0]          at,
    input  wire  [$clog2(CAPACITY+1)-1:0]        count,
    input  wire  signed [DATA_WIDTH-1:0]         din,
    input  wire  signed [DATA_WIDTH-1:0]         head,
    input  wire  signed [DATA_WIDTH-1:0]         left,
    input  wire                                  left_gt,
    input  wire  signed [DATA_WIDTH-1:0]         right,
    output logic signed [DATA_WIDTH-1:0]         q,
    output logic                                 gt,
    output logic signed [DATA_WIDTH-1:0]         pick
);
    import ple_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] IDX    = IW'(INDEX);
    localparam logic [CW-1:0] IDX_C  = CW'(INDEX);
    localparam logic [CW-1:0] IDX1_C = CW'(INDEX + 1);
    localparam logic          ODD    = 1'(INDEX % 2);

    logic signed [DATA_WIDTH-1:0] q_reg;
    logic signed [DATA_WIDTH-1:0] q_next;

    // next element held by this cell
    always_comb
    begin
        q_next = q_reg;
        unique case (cmd.op)
            CELL_INS:
            begin
                if (IDX > at)
                    q_next = left;
                else if (IDX == at)
                    q_next = din;
            end
            CELL_DEL:
            begin
                if (IDX >= at)
                    q_next = right;
            end
            CELL_SORT:
            begin
                // odd-even transposition: swap with the pair partner when out of order
                if ((ODD == cmd.phase) && (IDX1_C < count) && gt)
                    q_next = right;
                else if ((ODD != cmd.phase) && (IDX_C < count) && left_gt)
                    q_next = left;
            end
            CELL_ROT:
            begin
                // rotate the held run left, head wraps to the tail
                if (IDX1_C == count)
                    q_next = head;
                else if (IDX_C < count)
                    q_next = right;
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    // element storage
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q    = q_reg;
    assign gt   = (q_reg > right);
    assign pick = (IDX == at) ? q_reg : '0;

endmodule

`default_nettype wire

[rtl/positional_list_engine.sv]
// positional list engine: bounded ordered list of signed values in a chain of cells
// input beat (s_axis): action, 1-based position and value; one action per beat
// output beat (m_axis): status, item value, length after the action and empty flag;
//   tlast marks the final result of an input beat
// append, insert, delete and unused actions: one result, registered in the cycle after
//   the input beat; a new beat is taken in the cycle its result is taken, so these run
//   at one beat per cycle with a ready sink
// sort: odd-even transposition over the cell row, one pass per cycle, length passes;
//   the result is registered when the last pass ends; with fewer than two elements
//   it is registered straight from the input beat, as for append
// dump: one result per element read from the head cell while the row rotates,
//   one beat per cycle in S_DUMP while the sink is ready; an empty list gives one beat
// the cell row limits sort and dump to one element step per cycle
// reset clears the length and the control state; element cells are not cleared
// a stalled sink holds the result register and no new input beat is taken
// while a sort or dump runs, s_axis_tready stays low
`default_nettype none
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // action[2:0], position[9:3], value[41:10], zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status[1:0], item_value[33:2], length[40:34],
                                        // list_empty[41], zero
    output logic        m_axis_tlast
);
    import ple_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 7) ? CW : 7) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SORT = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   out_status_reg, out_status_next;
    logic signed [31:0]           out_item_reg, out_item_next;
    logic [6:0]                   out_len_reg, out_len_next;
    logic                         out_empty_reg, out_empty_next;
    logic                         out_last_reg, out_last_next;

    action_t                      in_action;
    logic [6:0]                   in_pos;
    logic signed [31:0]           in_value;
    logic                         s_fire;
    logic                         out_free;
    logic                         load;
    logic [PW-1:0]                pos_ext;
    logic [PW-1:0]                cnt_ext;

    cell_cmd_t                    cmd;
    logic [IW-1:0]                at;
    logic signed [DATA_WIDTH-1:0] din;
    logic signed [DATA_WIDTH-1:0] cell_q [CAPACITY];
    logic                         cell_gt [CAPACITY];
    logic signed [DATA_WIDTH-1:0] cell_pick [CAPACITY];
    logic signed [DATA_WIDTH-1:0] picked;

    // input beat fields
    assign in_action = action_t'(s_axis_tdata[2:0]);
    assign in_pos    = s_axis_tdata[9:3];
    assign in_value  = s_axis_tdata[41:10];
    assign din       = DATA_WIDTH'(in_value);
    assign pos_ext   = PW'(in_pos);
    assign cnt_ext   = PW'(count_reg);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // row of element cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] left_q;
            logic                         left_gt;
            logic signed [DATA_WIDTH-1:0] right_q;

            if (gi == 0)
            begin : g_first
                assign left_q  = '0;
                assign left_gt = 1'b0;
            end
            else
            begin : g_inner_l
                assign left_q  = cell_q[gi-1];
                assign left_gt = cell_gt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_q = '0;
            end
            else
            begin : g_inner_r
                assign right_q = cell_q[gi+1];
            end

            ple_cell #(
                .CAPACITY   (CAPACITY),
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (gi)
            ) u_cell (
                .clk     (clk),
                .cmd     (cmd),
                .at      (at),
                .count   (count_reg),
                .din     (din),
                .head    (cell_q[0]),
                .left    (left_q),
                .left_gt (left_gt),
                .right   (right_q),
                .q       (cell_q[gi]),
                .gt      (cell_gt[gi]),
                .pick    (cell_pick[gi])
            );
        end
    endgenerate

    // one-hot read of the addressed cell
    always_comb
    begin
        picked = '0;
        for (int k = 0; k < CAPACITY; k++)
            picked = picked | cell_pick[k];
    end

    // control and result staging
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        cmd.op          = CELL_HOLD;
        cmd.phase       = step_reg[0];
        at              = IW'(pos_ext - PW'(1));
        load            = 1'b0;
        out_status_next = STAT_OK;
        out_item_next   = '0;
        out_last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    unique case (in_action)
                        ACT_APPEND:
                        begin
                            load = 1'b1;
                            if (count_reg == CAP_C)
                                out_status_next = STAT_FULL;
                            else
                            begin
                                cmd.op     = CELL_INS;
                                at         = IW'(count_reg);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_INSERT:
                        begin
                            load = 1'b1;
                            if ((in_pos == 7'd0) || (pos_ext > cnt_ext + PW'(1)))
                                out_status_next = STAT_BAD_POS;
                            else if (count_reg == CAP_C)
                                out_status_next = STAT_FULL;
                            else
                            begin
                                cmd.op     = CELL_INS;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_DELETE:
                        begin
                            load = 1'b1;
                            if ((in_pos == 7'd0) || (pos_ext > cnt_ext))
                                out_status_next = STAT_BAD_POS;
                            else
                            begin
                                cmd.op        = CELL_DEL;
                                count_next    = count_reg - CW'(1);
                                out_item_next = 32'(picked);
                            end
                        end
                        ACT_SORT:
                        begin
                            if (count_reg < CW'(2))
                                load = 1'b1;
                            else
                            begin
                                state_next = S_SORT;
                                step_next  = '0;
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (count_reg == '0)
                                load = 1'b1;
                            else
                            begin
                                state_next = S_DUMP;
                                step_next  = '0;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_SORT:
            begin
                cmd.op = CELL_SORT;
                if (step_reg == count_reg - CW'(1))
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    step_next = step_reg + CW'(1);
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    cmd.op        = CELL_ROT;
                    load          = 1'b1;
                    out_item_next = 32'(cell_q[0]);
                    out_last_next = (step_reg == count_reg - CW'(1));
                    step_next     = step_reg + CW'(1);
                    if (out_last_next)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_len_next   = 7'(count_next);
        out_empty_next = (count_next == '0);
        if (load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= out_status_next;
            out_item_reg   <= out_item_next;
            out_len_reg    <= out_len_next;
            out_empty_reg  <= out_empty_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0, out_empty_reg, out_len_reg, out_item_reg, out_status_reg};

    // checks
    `PLE_CHECK(a_count_on_beat, !s_fire |=> $stable(count_reg), "length changed without input beat")
    `PLE_NEVER(a_count_bound, count_reg > CAP_C, "length above capacity")
    `PLE_NEVER(a_sort_no_result, (state_reg == S_SORT) && out_valid_reg, "result pending during sort")

endmodule

`default_nettype wire

[bench/positional_list_engine_tb.sv]
`default_nettype none

module positional_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int PHASE_ITEMS = 96;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = CAPACITY + 16;

    // action codes outside the package enum, answered with a plain ok beat
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] item_value;
        logic [6:0]  length;
        logic        list_empty;
        logic        last;
    } list_result_t;

    typedef struct {
        logic [2:0]  action;
        logic [6:0]  position;
        logic [31:0] value;
        int          reps;
        bit          typed;
        logic [1:0]  t_status;
        logic [31:0] t_item;
        logic [6:0]  t_len;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    // shadow copy of the list
    logic signed [31:0] shadow_cells [CAPACITY];
    int                 shadow_fill;

    list_result_t step_results[$];
    list_result_t expected_beats[$];
    stim_row_t    directed_rows[$];

    list_result_t seen_beat;
    list_result_t want_beat;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;
    int fail_count;
    int items_sent;
    int results_seen;
    int full_seen;
    int bad_pos_seen;
    int dumps_sent;

    positional_list_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #15_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // one result beat into the scratch list, length taken from the shadow state
    task automatic note_result(input logic [1:0] status, input logic [31:0] item,
                               input logic last);
        list_result_t r;
        r.status     = status;
        r.item_value = item;
        r.length     = shadow_fill[6:0];
        r.list_empty = (shadow_fill == 0);
        r.last       = last;
        step_results.push_back(r);
    endtask

    // works out the result beats of one action and updates the shadow list
    task automatic predict_list_step(input logic [2:0] act, input logic [6:0] pos,
                                     input logic [31:0] val);
        int at;
        int i;
        int j;
        logic signed [31:0] cur;
        step_results.delete();
        case (act)
            ACT_APPEND:
            begin
                if (shadow_fill >= CAPACITY)
                    note_result(STAT_FULL, '0, 1'b1);
                else
                begin
                    shadow_cells[shadow_fill] = val;
                    shadow_fill++;
                    note_result(STAT_OK, '0, 1'b1);
                end
            end
            ACT_INSERT:
            begin
                // position is checked before the full store
                if (pos < 1 || pos > shadow_fill + 1)
                    note_result(STAT_BAD_POS, '0, 1'b1);
                else if (shadow_fill >= CAPACITY)
                    note_result(STAT_FULL, '0, 1'b1);
                else
                begin
                    at = pos - 1;
                    for (i = shadow_fill; i > at; i--)
                        shadow_cells[i] = shadow_cells[i - 1];
                    shadow_cells[at] = val;
                    shadow_fill++;
                    note_result(STAT_OK, '0, 1'b1);
                end
            end
            ACT_DELETE:
            begin
                if (pos < 1 || pos > shadow_fill)
                    note_result(STAT_BAD_POS, '0, 1'b1);
                else
                begin
                    at  = pos - 1;
                    cur = shadow_cells[at];
                    for (i = at; i + 1 < shadow_fill; i++)
                        shadow_cells[i] = shadow_cells[i + 1];
                    shadow_fill--;
                    note_result(STAT_OK, cur, 1'b1);
                end
            end
            ACT_SORT:
            begin
                // signed ascending order
                for (i = 1; i < shadow_fill; i++)
                begin
                    cur = shadow_cells[i];
                    j   = i;
                    while (j > 0 && shadow_cells[j - 1] > cur)
                    begin
                        shadow_cells[j] = shadow_cells[j - 1];
                        j--;
                    end
                    shadow_cells[j] = cur;
                end
                note_result(STAT_OK, '0, 1'b1);
            end
            ACT_DUMP:
            begin
                // an empty list still answers with one beat
                if (shadow_fill == 0)
                    note_result(STAT_OK, '0, 1'b1);
                else
                    for (i = 0; i < shadow_fill; i++)
                        note_result(STAT_OK, shadow_cells[i], i == shadow_fill - 1);
            end
            default:
                note_result(STAT_OK, '0, 1'b1);
        endcase
    endtask

    // offer one beat after a random gap; returns with tvalid still high
    task automatic offer_beat(input logic [2:0] act, input logic [6:0] pos,
                              input logic [31:0] val, input bit typed,
                              input list_result_t typed_res);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, val, pos, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_list_step(act, pos, val);
        items_sent++;
        if (act == ACT_DUMP)
            dumps_sent++;
        if (typed)
            expected_beats.push_back(typed_res);
        else
            foreach (step_results[k])
                expected_beats.push_back(step_results[k]);
    endtask

    task automatic add_row(input logic [2:0] act, input logic [6:0] pos,
                           input logic [31:0] val, input int reps, input bit typed,
                           input logic [1:0] st, input logic [31:0] item,
                           input logic [6:0] len);
        stim_row_t row;
        row.action   = act;
        row.position = pos;
        row.value    = val;
        row.reps     = reps;
        row.typed    = typed;
        row.t_status = st;
        row.t_item   = item;
        row.t_len    = len;
        directed_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            fail_count++;
        end
    endtask

    // result sink: long hold-off on request, otherwise random stalls
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            @(posedge clk);
        end
    end

    // compare every accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_beat.status     = m_axis_tdata[1:0];
            seen_beat.item_value = m_axis_tdata[33:2];
            seen_beat.length     = m_axis_tdata[40:34];
            seen_beat.list_empty = m_axis_tdata[41];
            seen_beat.last       = m_axis_tlast;
            results_seen++;
            if (expected_beats.size() == 0)
            begin
                $display("%0t ns: unexpected result beat, expected none, actual %0h",
                         $time, seen_beat);
                fail_count++;
            end
            else
            begin
                want_beat = expected_beats.pop_front();
                check_field("status", 32'(want_beat.status), 32'(seen_beat.status));
                check_field("item_value", want_beat.item_value, seen_beat.item_value);
                check_field("length", 32'(want_beat.length), 32'(seen_beat.length));
                check_field("list_empty", 32'(want_beat.list_empty),
                            32'(seen_beat.list_empty));
                check_field("last", 32'(want_beat.last), 32'(seen_beat.last));
                if (want_beat.status == STAT_FULL)
                    full_seen++;
                if (want_beat.status == STAT_BAD_POS)
                    bad_pos_seen++;
            end
        end
    end

    // stimulus
    initial
    begin
        list_result_t typed_res;
        logic [2:0]   act;
        logic [6:0]   pos;
        logic [31:0]  val;
        int           r;
        bit           grow;
        int           app_w;
        int           ins_w;
        int           del_w;

        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        fail_count     = 0;
        items_sent     = 0;
        results_seen   = 0;
        full_seen      = 0;
        bad_pos_seen   = 0;
        dumps_sent     = 0;
        shadow_fill    = 0;

        // empty list, bad positions, extremes, sort and dump, spare actions, then a full store
        add_row(ACT_DUMP,        7'd0,   32'h0,         1,  1, STAT_OK,      32'h0, 7'd0);
        add_row(ACT_DELETE,      7'd1,   32'h0,         1,  1, STAT_BAD_POS, 32'h0, 7'd0);
        add_row(ACT_INSERT,      7'd0,   32'h1234_5678, 1,  1, STAT_BAD_POS, 32'h0, 7'd0);
        add_row(ACT_INSERT,      7'd2,   32'h1234_5678, 1,  1, STAT_BAD_POS, 32'h0, 7'd0);
        add_row(ACT_APPEND,      7'd127, 32'h7FFF_FFFF, 1,  1, STAT_OK,      32'h0, 7'd1);
        add_row(ACT_APPEND,      7'd0,   32'h8000_0000, 1,  1, STAT_OK,      32'h0, 7'd2);
        add_row(ACT_INSERT,      7'd1,   32'hFFFF_FFFF, 1,  1, STAT_OK,      32'h0, 7'd3);
        add_row(ACT_INSERT,      7'd4,   32'h0,         1,  1, STAT_OK,      32'h0, 7'd4);
        add_row(ACT_INSERT,      7'd127, 32'hAAAA_5555, 1,  1, STAT_BAD_POS, 32'h0, 7'd4);
        add_row(ACT_DELETE,      7'd0,   32'h0,         1,  1, STAT_BAD_POS, 32'h0, 7'd4);
        add_row(ACT_DELETE,      7'd5,   32'h0,         1,  1, STAT_BAD_POS, 32'h0, 7'd4);
        add_row(ACT_DUMP,        7'd0,   32'h0,         1,  0, STAT_OK,      32'h0, 7'd0);
        add_row(ACT_SORT,        7'd0,   32'h0,         1,  1, STAT_OK,      32'h0, 7'd4);
        add_row(ACT_DUMP,        7'd0,   32'h0,         1,  0, STAT_OK,      32'h0, 7'd0);
        add_row(ACT_DELETE,      7'd4,   32'h0,         1,  1, STAT_OK, 32'h7FFF_FFFF, 7'd3);
        add_row(ACT_DELETE,      7'd1,   32'h0,         1,  1, STAT_OK, 32'h8000_0000, 7'd2);
        add_row(ACT_SPARE_FIRST, 7'd3,   32'hFFFF_FFFF, 1,  1, STAT_OK,      32'h0, 7'd2);
        add_row(ACT_SPARE_LAST,  7'd127, 32'h8000_0000, 1,  1, STAT_OK,      32'h0, 7'd2);
        add_row(ACT_APPEND,      7'd0,   32'hF000_0010, 62, 0, STAT_OK,      32'h0, 7'd0);
        add_row(ACT_APPEND,      7'd0,   32'h5555_AAAA, 1,  1, STAT_FULL,    32'h0, 7'd64);
        add_row(ACT_INSERT,      7'd65,  32'h5555_AAAA, 1,  1, STAT_FULL,    32'h0, 7'd64);
        add_row(ACT_INSERT,      7'd66,  32'h5555_AAAA, 1,  1, STAT_BAD_POS, 32'h0, 7'd64);
        add_row(ACT_INSERT,      7'd1,   32'h5555_AAAA, 1,  1, STAT_FULL,    32'h0, 7'd64);
        add_row(ACT_SORT,        7'd0,   32'h0,         1,  0, STAT_OK,      32'h0, 7'd0);
        add_row(ACT_DUMP,        7'd0,   32'h0,         1,  0, STAT_OK,      32'h0, 7'd0);
        add_row(ACT_DELETE,      7'd64,  32'h0,         1,  0, STAT_OK,      32'h0, 7'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
        begin
            typed_res.status     = directed_rows[i].t_status;
            typed_res.item_value = directed_rows[i].t_item;
            typed_res.length     = directed_rows[i].t_len;
            typed_res.list_empty = (directed_rows[i].t_len == 0);
            typed_res.last       = 1'b1;
            for (int k = 0; k < directed_rows[i].reps; k++)
                offer_beat(directed_rows[i].action, directed_rows[i].position,
                           directed_rows[i].value + k, directed_rows[i].typed, typed_res);
        end

        // random phases: growing and shrinking lists under different idling
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    hold_left      = HOLD_CYCLES;
                end
                1:
                begin
                    src_idle_pct   = 53;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 53;
                end
                default:
                begin
                    src_idle_pct   = 16;
                    sink_stall_pct = 16;
                end
            endcase
            grow  = (p % 2 == 0);
            app_w = grow ? 40 : 15;
            ins_w = grow ? 25 : 15;
            del_w = grow ? 17 : 52;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // value: wide random, extremes, or a narrow band for duplicates
                r = $urandom_range(9);
                if (r < 5)
                    val = $urandom;
                else if (r < 7)
                begin
                    case ($urandom_range(3))
                        0:       val = 32'h8000_0000;
                        1:       val = 32'h7FFF_FFFF;
                        2:       val = 32'h0;
                        default: val = 32'hFFFF_FFFF;
                    endcase
                end
                else
                    val = $urandom_range(16) - 8;

                pos = 7'($urandom_range(127));
                r   = $urandom_range(99);
                if (r < app_w)
                    act = ACT_APPEND;
                else if (r < app_w + ins_w)
                begin
                    act = ACT_INSERT;
                    if ($urandom_range(99) < 85)
                        pos = 7'($urandom_range(shadow_fill + 1, 1));
                    else if ($urandom_range(1) == 0)
                        pos = 7'd0;
                    else
                        pos = 7'($urandom_range(127, shadow_fill + 2));
                end
                else if (r < app_w + ins_w + del_w)
                begin
                    act = ACT_DELETE;
                    if (shadow_fill > 0 && $urandom_range(99) < 85)
                        pos = 7'($urandom_range(shadow_fill, 1));
                    else if ($urandom_range(1) == 0)
                        pos = 7'd0;
                    else
                        pos = 7'($urandom_range(127, shadow_fill + 1));
                end
                else if (r < 88)
                    act = ACT_SORT;
                else if (r < 94)
                    act = ACT_DUMP;
                else
                    act = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));

                offer_beat(act, pos, val, 1'b0, typed_res);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain and watch for stray beats
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d input beats (%0d dumps) and %0d result beats", items_sent,
                 dumps_sent, results_seen);
        $display("with %0d full-store and %0d bad-position answers", full_seen, bad_pos_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
